// File: design/mcpc_pkg.sv
`default_nettype none

package mcpc_pkg;

  // Channel count and the skip registers that back it
  localparam int CHANNELS   = 5;
  localparam int SKIP_REGS  = 5;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SKIP_IDX_W = (SKIP_REGS > 1) ? $clog2(SKIP_REGS) : 1;

  // Fixed field widths
  localparam int CH_W      = 3;
  localparam int CAP_W     = 16;
  localparam int OVF_W     = 16;
  localparam int PERIOD_W  = 32;
  localparam int SKIP_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Captures below this value with a pending overflow belong to the next wrap
  localparam logic [CAP_W-1:0] RACE_LIMIT = 16'h8000;

  typedef enum logic [0:0] {
    KIND_OVERFLOW = 1'b0,
    KIND_EDGE     = 1'b1
  } kind_t;

  // Input payload, channel in the lowest bits
  typedef struct packed {
    logic             overflow_pending;
    logic [CAP_W-1:0] capture_value;
    logic [CH_W-1:0]  channel;
  } item_t;

endpackage

`default_nettype wire

// File: design/multi_channel_period_capture_core.sv
`default_nettype none
// A result passes from the input register to the result register, which drives m_tvalid.
// Throughput: one item per cycle; while a finished result waits on m_tready, items that
// give no result still pass, and a measuring edge holds in the input register until then.
// Reset (rst, synchronous, active high): skip registers read 0, overflow count and
// per-channel references read 0, per-channel skip counters read 1, both stages empty.

module multi_channel_period_capture_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [mcpc_pkg::IN_DATA_W-1:0]    s_tdata,  // channel[2:0], capture_value[18:3],
                                                           // overflow_pending[19], zero fill
  input  wire logic                              s_tuser,  // kind[0]
  // Result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [mcpc_pkg::OUT_DATA_W-1:0]   m_tdata,  // result_channel[2:0],
                                                           // period_ticks[34:3], zero fill
  // Configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mcpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mcpc_pkg::SKIP_W-1:0]       cfg_data
);

  // Skip registers, one per channel that has one
  logic [mcpc_pkg::SKIP_W-1:0] skip_reg [mcpc_pkg::SKIP_REGS];

  // Shared and per-channel measurement state
  logic [mcpc_pkg::OVF_W-1:0]  overflow_count;
  logic [mcpc_pkg::CAP_W-1:0]  last_capture   [mcpc_pkg::CHANNELS];
  logic [mcpc_pkg::OVF_W-1:0]  last_overflow  [mcpc_pkg::CHANNELS];
  logic [mcpc_pkg::SKIP_W-1:0] skip_remaining [mcpc_pkg::CHANNELS];

  // Input register
  logic                        in_valid;
  mcpc_pkg::item_t             in_item;
  mcpc_pkg::kind_t             in_kind;

  // Result register
  logic [mcpc_pkg::CH_W-1:0]     out_channel;
  logic [mcpc_pkg::PERIOD_W-1:0] out_period;

  // Decode of the held item
  logic [mcpc_pkg::CH_IDX_W-1:0]   ch_idx;
  logic [mcpc_pkg::SKIP_IDX_W-1:0] skip_idx;
  logic                            is_edge;
  logic                            ch_ok;
  logic                            measure;
  logic                            fire;
  logic [mcpc_pkg::SKIP_W-1:0]     reload;
  logic [mcpc_pkg::OVF_W-1:0]      overflow_used;
  logic [mcpc_pkg::PERIOD_W-1:0]   period_ticks;

  assign ch_idx   = mcpc_pkg::CH_IDX_W'(in_item.channel);
  assign skip_idx = mcpc_pkg::SKIP_IDX_W'(in_item.channel);
  assign is_edge  = (in_kind == mcpc_pkg::KIND_EDGE);
  assign ch_ok    = (int'(in_item.channel) < mcpc_pkg::CHANNELS);
  // A measuring edge is a valid channel whose skip counter has run out
  assign measure  = is_edge && ch_ok && (skip_remaining[ch_idx] == '0);
  // Retire the held item unless its result has nowhere to go
  assign fire     = in_valid && (!measure || !m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;
  assign cfg_ready = 1'b1;

  // Channels beyond the register list reload with zero
  assign reload = (int'(in_item.channel) < mcpc_pkg::SKIP_REGS) ? skip_reg[skip_idx] : '0;

  mcpc_period_calc u_calc (
    .overflow_count   (overflow_count),
    .last_capture     (last_capture[ch_idx]),
    .last_overflow    (last_overflow[ch_idx]),
    .capture_value    (in_item.capture_value),
    .overflow_pending (in_item.overflow_pending),
    .overflow_used    (overflow_used),
    .period_ticks     (period_ticks)
  );

  assign m_tdata = {{(mcpc_pkg::OUT_DATA_W - mcpc_pkg::PERIOD_W - mcpc_pkg::CH_W){1'b0}},
                    out_period, out_channel};

  // Control and measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      m_tvalid       <= 1'b0;
      overflow_count <= '0;
      for (int c = 0; c < mcpc_pkg::SKIP_REGS; c++) begin
        skip_reg[c] <= '0;
      end
      for (int c = 0; c < mcpc_pkg::CHANNELS; c++) begin
        last_capture[c]   <= '0;
        last_overflow[c]  <= '0;
        skip_remaining[c] <= mcpc_pkg::SKIP_W'(1);
      end
    end else begin
      // Take configuration writes; drop indexes past the register list
      if (cfg_valid && (int'(cfg_index) < mcpc_pkg::SKIP_REGS)) begin
        skip_reg[mcpc_pkg::SKIP_IDX_W'(cfg_index)] <= cfg_data;
      end

      // Input register fills on accept, empties when its item retires
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end

      // Result register loads on a measuring edge, clears when taken
      if (fire && measure) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (fire) begin
        if (!is_edge) begin
          // Advance the shared overflow count
          overflow_count <= overflow_count + mcpc_pkg::OVF_W'(1);
        end else if (ch_ok) begin
          if (measure) begin
            // Store new references and reload the skip counter
            last_capture[ch_idx]   <= in_item.capture_value;
            last_overflow[ch_idx]  <= overflow_used;
            skip_remaining[ch_idx] <= reload;
          end else begin
            skip_remaining[ch_idx] <= skip_remaining[ch_idx] - mcpc_pkg::SKIP_W'(1);
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= mcpc_pkg::item_t'(s_tdata[$bits(mcpc_pkg::item_t)-1:0]);
      in_kind <= mcpc_pkg::kind_t'(s_tuser);
    end
    if (fire && measure) begin
      out_channel <= in_item.channel;
      out_period  <= period_ticks;
    end
  end

`ifndef SYNTHESIS
  // An overflow item that retires advances the shared count by one
  a_ovf_advance: assert property (@(posedge clk) disable iff (rst)
    (fire && !is_edge) |=> (overflow_count == $past(overflow_count) + mcpc_pkg::OVF_W'(1)))
    else $error("overflow count did not advance");

  // A skipped edge counts its channel down by one
  a_skip_count: assert property (@(posedge clk) disable iff (rst)
    (fire && is_edge && ch_ok && !measure) |=>
      (skip_remaining[$past(ch_idx)] == $past(skip_remaining[ch_idx]) - mcpc_pkg::SKIP_W'(1)))
    else $error("skip counter did not count down");

  // An empty input register always takes an item
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled with empty stage");

  // A new result only appears from a measuring edge
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid && !m_tready)) |-> $past(fire && measure))
    else $error("result without measuring edge");
`endif

endmodule

`default_nettype wire

// File: design/mcpc_period_calc.sv
`default_nettype none

module mcpc_period_calc (
  input  wire logic [mcpc_pkg::OVF_W-1:0]    overflow_count,
  input  wire logic [mcpc_pkg::CAP_W-1:0]    last_capture,
  input  wire logic [mcpc_pkg::OVF_W-1:0]    last_overflow,
  input  wire logic [mcpc_pkg::CAP_W-1:0]    capture_value,
  input  wire logic                          overflow_pending,
  output logic      [mcpc_pkg::OVF_W-1:0]    overflow_used,
  output logic      [mcpc_pkg::PERIOD_W-1:0] period_ticks
);

  logic [mcpc_pkg::OVF_W-1:0] ovf_diff;

  always_comb begin
    // Count a pending overflow when the capture sits in the low half of the timer
    if (overflow_pending && (capture_value < mcpc_pkg::RACE_LIMIT)) begin
      overflow_used = overflow_count + mcpc_pkg::OVF_W'(1);
    end else begin
      overflow_used = overflow_count;
    end
    ovf_diff     = overflow_used - last_overflow;
    period_ticks = {ovf_diff, {mcpc_pkg::CAP_W{1'b0}}}
                 + {{(mcpc_pkg::PERIOD_W - mcpc_pkg::CAP_W){1'b0}}, capture_value}
                 - {{(mcpc_pkg::PERIOD_W - mcpc_pkg::CAP_W){1'b0}}, last_capture};
  end

endmodule

`default_nettype wire
